@@ design/kfss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kfss_pkg;

   // Number of slots that the tree covers; node i sits at memory address i - 1.
   localparam int MAX_SLOTS = 1024;
   localparam int ADDR_W = $clog2(MAX_SLOTS);
   // Width of counts, ranks and slot numbers (holds MAX_SLOTS itself).
   localparam int CNT_W = 11;
   // Width of a node number plus a step, which may pass MAX_SLOTS.
   localparam int SUM_W = CNT_W + 1;
   // First step of the descending walk: the smallest power of two above MAX_SLOTS / 2.
   localparam int TOP_STEP = 1 << $clog2(MAX_SLOTS / 2 + 1);
   // Reset value of the slot count register and the free count that follows from it.
   localparam int CNT_RESET = 1024;
   localparam int FREE_RESET = (CNT_RESET > MAX_SLOTS) ? MAX_SLOTS : CNT_RESET;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);
   localparam logic [CNT_W-1:0] TOP_CNT = CNT_W'(TOP_STEP);
   localparam logic [CNT_W-1:0] CNT_RESET_VAL = CNT_W'(CNT_RESET);
   localparam logic [CNT_W-1:0] FREE_RESET_VAL = CNT_W'(FREE_RESET);

   localparam logic MODE_RESTART = 1'b0;
   localparam logic MODE_SELECT = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [CNT_W-1:0] rank;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] slot;
      logic             error;
      logic [CNT_W-1:0] free_left;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic start_walk;
      logic walk_step;
      logic upd_start;
      logic upd_step;
      logic start_clear;
      logic clear_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_select;
      logic req_bad;
      logic step_last;
      logic upd_last;
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ design/kth_free_slot_select.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Selects the k-th free slot out of 1024 numbered slots, using a binary indexed
// tree of free counts held in a single on-chip memory. A restart transaction
// (mode 0) makes slots 1 to slot_count free, with slot_count saturating at 1024,
// and answers with slot 0, no error and the new free count. A select
// transaction (mode 1) walks the tree from the top, one memory read per level,
// to find the slot of the given rank, then marks it taken by stepping up the
// tree once per affected node; it answers with the 1-based slot number, no error
// and the free count left. A rank of zero or above the free count answers with
// slot 0, the error flag and the unchanged free count, and changes nothing.
// A select runs the walk reads and then one read-modify-write per node of the
// update chain; a rejected select skips both. A restart rewrites every tree
// node, one per cycle. After reset the same rebuild runs, during which
// req_stall stays high. Only one transaction is in work at a time, but the
// next one is accepted while a finished result still waits on a stalled
// result channel. slot_count may be written at any time when the block is
// idle; it is used at the next restart only.

module kth_free_slot_select import kfss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   cmd_type    ctl_cmd;
   status_type dp_status;

   // The controller sequences the walk, the update chain and the rebuild sweep.
   kfss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   // The datapath holds the tree memory, the walk registers and the result register.
   kfss_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .req_data  (req_data),
      .cmd       (ctl_cmd),
      .status    (dp_status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Once a transaction is taken the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block accepted a transaction without going busy");

   // The tree memory has one write port: sweep and update never write together.
   assert property (@(posedge clock) disable iff (reset)
      !(ctl_cmd.clear_step && ctl_cmd.upd_step))
      else $error("sweep and update chain both write the tree");

   // A rejected select never names a slot.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error) |-> (rsp_data.slot == '0))
      else $error("error result carries a slot number");

   // The free count can never exceed the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.free_left <= MAX_CNT))
      else $error("free count above slot total");

endmodule

`default_nettype wire

@@ design/kfss_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kfss_ctrl import kfss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_INIT      = 7'b0000001,
      S_IDLE      = 7'b0000010,
      S_WALK      = 7'b0000100,
      S_UPD_START = 7'b0001000,
      S_UPD       = 7'b0010000,
      S_CLEAR     = 7'b0100000,
      S_DONE      = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_INIT: begin
            // Tree build after reset; no transaction is produced.
            cmd.clear_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!status.req_select) begin
                  cmd.start_clear = 1'b1;
                  state_in = S_CLEAR;
               end else if (status.req_bad) begin
                  state_in = S_DONE;
               end else begin
                  cmd.start_walk = 1'b1;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.step_last) begin
               state_in = S_UPD_START;
            end
         end
         S_UPD_START: begin
            cmd.upd_start = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd_step = 1'b1;
            if (status.upd_last) begin
               state_in = S_DONE;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ design/kfss_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kfss_datapath import kfss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [CNT_W-1:0] csr_data,
   output logic             csr_ready,
   input  req_type          req_data,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   logic [CNT_W-1:0]  tree_ff [MAX_SLOTS];
   logic [CNT_W-1:0]  rd_data_ff;

   logic [CNT_W-1:0]  slot_count_ff;
   logic [CNT_W-1:0]  free_total_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  sweep_ff;
   logic              mode_ff;
   logic              err_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  step_ff;
   logic [SUM_W-1:0]  cand_ff;
   logic [CNT_W-1:0]  upd_i_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [CNT_W-1:0]  n_sat;
   logic              req_bad;
   logic              take;
   logic [CNT_W-1:0]  pos_in;
   logic [CNT_W-1:0]  rem_in;
   logic [CNT_W-1:0]  step_in;
   logic [SUM_W-1:0]  cand_in;
   logic [SUM_W-1:0]  cand_m1;
   logic [CNT_W-1:0]  upd_low;
   logic [SUM_W-1:0]  upd_next;
   logic [SUM_W-1:0]  upd_next_m1;
   logic [CNT_W-1:0]  upd_m1;
   logic [CNT_W-1:0]  upd_dec;
   logic [CNT_W-1:0]  sw_low;
   logic [CNT_W-1:0]  sw_lo;
   logic [CNT_W-1:0]  sw_hi;
   logic [CNT_W-1:0]  sw_m1;
   logic [CNT_W-1:0]  init_val;
   logic [CNT_W-1:0]  slot_val;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic              wr_en;

   assign csr_ready = 1'b1;

   assign n_sat = (slot_count_ff > MAX_CNT) ? MAX_CNT : slot_count_ff;
   assign req_bad = (req_data.rank == '0) || (req_data.rank > free_total_ff);

   // One step of the descending walk: the node read last cycle decides the move.
   assign take = (cand_ff <= SUM_W'(MAX_SLOTS)) && (rd_data_ff < rem_ff);
   assign pos_in = take ? cand_ff[CNT_W-1:0] : pos_ff;
   assign rem_in = take ? (rem_ff - rd_data_ff) : rem_ff;
   assign step_in = step_ff >> 1;
   assign cand_in = {1'b0, pos_in} + {1'b0, step_in};
   assign cand_m1 = cand_in - SUM_W'(1);

   // Update chain: node i, then i plus its lowest set bit.
   assign upd_low = upd_i_ff & (~upd_i_ff + CNT_W'(1));
   assign upd_next = {1'b0, upd_i_ff} + {1'b0, upd_low};
   assign upd_next_m1 = upd_next - SUM_W'(1);
   assign upd_m1 = upd_i_ff - CNT_W'(1);
   assign upd_dec = rd_data_ff - CNT_W'(rd_data_ff != '0);

   // Build value of node i: free slots of 1..n that fall in (i - lowbit(i), i].
   assign sw_low = sweep_ff & (~sweep_ff + CNT_W'(1));
   assign sw_lo = sweep_ff - sw_low;
   assign sw_hi = (sweep_ff < n_ff) ? sweep_ff : n_ff;
   assign sw_m1 = sweep_ff - CNT_W'(1);
   assign init_val = (sw_hi > sw_lo) ? (sw_hi - sw_lo) : '0;

   assign slot_val = ((mode_ff == MODE_SELECT) && !err_ff) ? (pos_ff + CNT_W'(1)) : '0;

   always_comb begin
      rd_addr = '0;
      if (cmd.start_walk) begin
         rd_addr = ADDR_W'(TOP_STEP - 1);
      end else if (cmd.walk_step) begin
         rd_addr = cand_m1[ADDR_W-1:0];
      end else if (cmd.upd_start) begin
         rd_addr = pos_ff[ADDR_W-1:0];
      end else if (cmd.upd_step) begin
         rd_addr = upd_next_m1[ADDR_W-1:0];
      end
   end

   assign wr_en = cmd.clear_step || cmd.upd_step;
   assign wr_addr = cmd.clear_step ? sw_m1[ADDR_W-1:0] : upd_m1[ADDR_W-1:0];
   assign wr_data = cmd.clear_step ? init_val : upd_dec;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= tree_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= CNT_RESET_VAL;
         free_total_ff <= FREE_RESET_VAL;
         n_ff <= FREE_RESET_VAL;
         sweep_ff <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            slot_count_ff <= csr_data;
         end
         if (cmd.start_clear) begin
            free_total_ff <= n_sat;
            n_ff <= n_sat;
            sweep_ff <= CNT_W'(1);
         end else begin
            if (cmd.upd_step && status.upd_last) begin
               free_total_ff <= free_total_ff - CNT_W'(1);
            end
            if (cmd.clear_step) begin
               sweep_ff <= sweep_ff + CNT_W'(1);
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_data.mode;
         err_ff <= (req_data.mode == MODE_SELECT) && req_bad;
      end
      if (cmd.start_walk) begin
         pos_ff <= '0;
         rem_ff <= req_data.rank;
         step_ff <= TOP_CNT;
         cand_ff <= SUM_W'(TOP_STEP);
      end else if (cmd.walk_step) begin
         pos_ff <= pos_in;
         rem_ff <= rem_in;
         step_ff <= step_in;
         cand_ff <= cand_in;
      end
      if (cmd.upd_start) begin
         upd_i_ff <= pos_ff + CNT_W'(1);
      end else if (cmd.upd_step) begin
         upd_i_ff <= upd_next[CNT_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.slot <= slot_val;
         rsp_data_ff.error <= err_ff;
         rsp_data_ff.free_left <= free_total_ff;
      end
   end

   assign status.req_select = (req_data.mode == MODE_SELECT);
   assign status.req_bad = req_bad;
   assign status.step_last = (step_ff == CNT_W'(1));
   assign status.upd_last = (upd_next > SUM_W'(MAX_SLOTS));
   assign status.sweep_last = (sweep_ff == MAX_CNT);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import kfss_pkg::*;

   // Run limit in clock cycles. A correct run needs roughly 1100 selects,
   // fewer than 80 restarts and the rebuild after reset, all with idle bursts
   // on both sides, and the limit is several times what that takes.
   localparam int CYCLE_LIMIT = 600000;
   localparam int NUM_PHASES = 14;
   localparam int PHASE_ITEMS = 80;
   localparam int PHASE_RESTARTS = 4;
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_PRINTED = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;

   kth_free_slot_select uut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A 20 ns clock: low for half a period, then high for the other half.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Own model of the block: a binary indexed tree over the slots in which
   // node i counts the free slots in (i - lowbit(i), i], the running free
   // count, and the slot count register as last written.
   // ------------------------------------------------------------------------
   int unsigned      free_tree [1:MAX_SLOTS];
   int unsigned      free_now;
   logic [CNT_W-1:0] slot_count_reg;

   // Results that the block owes, oldest first.
   rsp_type          slot_answers [$];

   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               req_idle_pct = 0;
   int               rsp_idle_pct = 0;
   int               stall_run = 0;

   // Lays the tree out afresh with slots 1 to slot_count free; a count above
   // the number of slots saturates.
   function automatic void refill_tree();
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      n = slot_count_reg;
      if (n > MAX_SLOTS) begin
         n = MAX_SLOTS;
      end
      for (int unsigned i = 1; i <= MAX_SLOTS; i++) begin
         lo = i - (i & (~i + 1));
         hi = (i < n) ? i : n;
         free_tree[i] = (hi > lo) ? hi - lo : 0;
      end
      free_now = n;
   endfunction

   // Works out the answer to one accepted transaction and moves the model on.
   function automatic rsp_type take_kth_free(req_type r);
      rsp_type     a;
      int unsigned pos;
      int unsigned rem;
      int unsigned step;
      int unsigned nxt;
      int unsigned i;
      a = '0;
      if (r.mode == MODE_RESTART) begin
         refill_tree();
         a.free_left = CNT_W'(free_now);
         return a;
      end
      // A rank of zero, or one beyond the free count, leaves everything as it was.
      if (r.rank == 0 || r.rank > free_now) begin
         a.error = 1'b1;
         a.free_left = CNT_W'(free_now);
         return a;
      end
      // Walk down from the largest power of two that fits, keeping the
      // largest position whose prefix count is still below the rank.
      pos = 0;
      rem = r.rank;
      step = 1;
      while (step <= MAX_SLOTS / 2) begin
         step = step << 1;
      end
      for (; step != 0; step = step >> 1) begin
         nxt = pos + step;
         if (nxt <= MAX_SLOTS && free_tree[nxt] < rem) begin
            pos = nxt;
            rem = rem - free_tree[nxt];
         end
      end
      pos = pos + 1;
      // Mark the slot taken in every node that covers it.
      for (i = pos; i != 0 && i <= MAX_SLOTS; i = i + (i & (~i + 1))) begin
         if (free_tree[i] != 0) begin
            free_tree[i] = free_tree[i] - 1;
         end
      end
      free_now = free_now - 1;
      a.slot = CNT_W'(pos);
      a.free_left = CNT_W'(free_now);
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // Checking.
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) begin
         $display("%0t ns: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Every result that the channel hands over is matched, field by field,
   // against the oldest answer still owed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (slot_answers.size() == 0) begin
            note_mismatch($sformatf("result slot=%0d error=%0b free_left=%0d with none owed",
                                    rsp_data.slot, rsp_data.error, rsp_data.free_left));
         end else begin
            want = slot_answers.pop_front();
            if (rsp_data.slot !== want.slot) begin
               note_mismatch($sformatf("slot %0d, expected %0d", rsp_data.slot, want.slot));
            end
            if (rsp_data.error !== want.error) begin
               note_mismatch($sformatf("error %0b, expected %0b", rsp_data.error, want.error));
            end
            if (rsp_data.free_left !== want.free_left) begin
               note_mismatch($sformatf("free_left %0d, expected %0d",
                                       rsp_data.free_left, want.free_left));
            end
         end
      end
   end

   // The result side stalls in bursts, changing only at the falling edge.
   // Stall goes low after each burst before another can start, so bursts
   // never run together.
   always @(negedge clock) begin
      if (stall_run == 0 && !rsp_stall && $urandom_range(99) < rsp_idle_pct) begin
         stall_run = $urandom_range(1, 5);
      end
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Driving. Every task below is entered and left at a falling edge.
   // ------------------------------------------------------------------------

   // Offers one transaction, after an optional idle burst, and waits until it
   // is accepted. The answer owed is either the one typed into the table or
   // the model's own; the model is moved on in both cases.
   task automatic send_req(input req_type r, input bit typed, input rsp_type want);
      rsp_type model_answer;
      int      gap;
      if ($urandom_range(99) < req_idle_pct) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      model_answer = take_kth_free(r);
      slot_answers.push_back(typed ? want : model_answer);
      @(negedge clock);
   endtask

   // Stops offering transactions and waits until every answer owed has come,
   // so that the block is idle.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (slot_answers.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Writes the slot count register. The extra falling edge at the end keeps
   // two writes in a row from lowering and raising csr_valid in one step.
   task automatic write_slot_count(input logic [CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      slot_count_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Directed table. A row either writes the register or offers one
   // transaction; where the answer is obvious it is typed in, otherwise the
   // model supplies it.
   // ------------------------------------------------------------------------
   typedef struct {
      bit               is_csr;
      logic [CNT_W-1:0] csr_value;
      req_type          req;
      bit               typed;
      rsp_type          want;
   } drill_row;

   drill_row drill [$];

   function automatic drill_row csr_row(input int value);
      drill_row d;
      d = '{is_csr: 1'b1, csr_value: CNT_W'(value), req: '0, typed: 1'b0, want: '0};
      return d;
   endfunction

   function automatic drill_row item_row(input logic mode, input int rank);
      drill_row d;
      d = '{is_csr: 1'b0, csr_value: '0, req: '{mode: mode, rank: CNT_W'(rank)},
            typed: 1'b0, want: '0};
      return d;
   endfunction

   function automatic drill_row check_row(input logic mode, input int rank, input int slot,
                                          input logic err, input int left);
      drill_row d;
      d = item_row(mode, rank);
      d.typed = 1'b1;
      d.want = '{slot: CNT_W'(slot), error: err, free_left: CNT_W'(left)};
      return d;
   endfunction

   // Picks the next random transaction of a phase. Most are selects with a
   // rank that the free count allows; some are out-of-range ranks, and a few
   // are restarts, which also refill the slots once they have run out.
   function automatic req_type pick_req(inout int restarts_left);
      req_type r;
      int      roll;
      bit      bad;
      roll = $urandom_range(99);
      bad = (roll >= 4 && roll < 14);
      r.mode = MODE_SELECT;
      r.rank = '0;
      if ((roll < 4 || (!bad && free_now == 0)) && restarts_left > 0) begin
         restarts_left--;
         r.mode = MODE_RESTART;
         r.rank = CNT_W'($urandom_range(0, 2047));
      end else if (bad || free_now == 0) begin
         if ($urandom_range(1) == 0) begin
            r.rank = '0;
         end else begin
            r.rank = CNT_W'($urandom_range(free_now + 1, 2047));
         end
      end else begin
         case ($urandom_range(9))
            0: r.rank = CNT_W'(1);
            1: r.rank = CNT_W'(free_now);
            default: r.rank = CNT_W'($urandom_range(1, free_now));
         endcase
      end
      return r;
   endfunction

   // Cycle counter: a hung block ends the run here.
   initial begin
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int          restarts_left;
      int          count_value;
      req_type     r;

      // At reset the slot count is 1024 and every slot is free.
      slot_count_reg = CNT_RESET_VAL;
      refill_tree();

      // Ranks at and beyond the free count, a restart that carries a rank it
      // must ignore, a register write between restarts that must not act
      // before the next restart, a count of zero so that selects find nothing
      // free, a count of one, and a count above the number of slots.
      drill.push_back(check_row(MODE_SELECT, 0, 0, 1'b1, 1024));
      drill.push_back(check_row(MODE_SELECT, 1025, 0, 1'b1, 1024));
      drill.push_back(check_row(MODE_SELECT, 2047, 0, 1'b1, 1024));
      drill.push_back(check_row(MODE_SELECT, 1, 1, 1'b0, 1023));
      drill.push_back(check_row(MODE_SELECT, 1023, 1024, 1'b0, 1022));
      drill.push_back(item_row(MODE_SELECT, 512));
      drill.push_back(check_row(MODE_SELECT, 1022, 0, 1'b1, 1021));
      drill.push_back(check_row(MODE_RESTART, 2047, 0, 1'b0, 1024));
      drill.push_back(check_row(MODE_SELECT, 1024, 1024, 1'b0, 1023));
      drill.push_back(csr_row(0));
      drill.push_back(item_row(MODE_SELECT, 700));
      drill.push_back(check_row(MODE_RESTART, 0, 0, 1'b0, 0));
      drill.push_back(check_row(MODE_SELECT, 1, 0, 1'b1, 0));
      drill.push_back(check_row(MODE_SELECT, 0, 0, 1'b1, 0));
      drill.push_back(csr_row(1));
      drill.push_back(check_row(MODE_RESTART, 5, 0, 1'b0, 1));
      drill.push_back(check_row(MODE_SELECT, 1, 1, 1'b0, 0));
      drill.push_back(check_row(MODE_SELECT, 1, 0, 1'b1, 0));
      drill.push_back(csr_row(2047));
      drill.push_back(check_row(MODE_RESTART, 0, 0, 1'b0, 1024));
      drill.push_back(check_row(MODE_SELECT, 1024, 1024, 1'b0, 1023));
      drill.push_back(csr_row(6));
      drill.push_back(check_row(MODE_RESTART, 0, 0, 1'b0, 6));
      drill.push_back(check_row(MODE_SELECT, 3, 3, 1'b0, 5));
      drill.push_back(item_row(MODE_SELECT, 3));
      drill.push_back(item_row(MODE_SELECT, 4));
      drill.push_back(item_row(MODE_SELECT, 3));

      // Synchronous reset, released at a falling edge. The
      // block then rebuilds its tree and holds req_stall high meanwhile,
      // which the handshake absorbs.
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_pct = 20;
      rsp_idle_pct = 20;
      foreach (drill[n]) begin
         if (drill[n].is_csr) begin
            settle_block();
            write_slot_count(drill[n].csr_value);
         end else begin
            send_req(drill[n].req, drill[n].typed, drill[n].want);
         end
      end

      // Random phases. Each one writes the register while the block is idle,
      // restarts, and then runs a mixture of selects and the odd restart.
      // Idling varies from phase to phase, and the last phases have none.
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_block();
         if (p >= NUM_PHASES - 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 45);
            rsp_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 45);
         end
         case (p)
            0: count_value = 2047;
            1: count_value = 0;
            2: count_value = 1;
            3: count_value = 1024;
            4: count_value = 1023;
            default: begin
               if ($urandom_range(3) == 0) begin
                  count_value = $urandom_range(0, 2047);
               end else begin
                  count_value = $urandom_range(2, 200);
               end
            end
         endcase
         // Now and then a write that the next one overrides.
         if ($urandom_range(3) == 0) begin
            write_slot_count(CNT_W'($urandom_range(0, 2047)));
         end
         write_slot_count(CNT_W'(count_value));

         r = '{mode: MODE_RESTART, rank: CNT_W'($urandom_range(0, 2047))};
         send_req(r, 1'b0, '0);
         restarts_left = PHASE_RESTARTS;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = pick_req(restarts_left);
            send_req(r, 1'b0, '0);
         end
      end

      // Let every answer owed come out, then give the block a little longer
      // in case anything further appears on the result channel.
      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
